### rtl/b64le_pkg.sv
`timescale 1ns / 1ps
package b64le_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [5:0] GPL_RESET = 6'd19;
   localparam logic [7:0] CHAR_PAD  = 8'd61;
   localparam logic [7:0] CHAR_CR   = 8'd13;
   localparam logic [7:0] CHAR_LF   = 8'd10;

   // number of alphabet characters in a group
   localparam logic [2:0] NSYM_PAD2 = 3'd2;
   localparam logic [2:0] NSYM_PAD1 = 3'd3;
   localparam logic [2:0] NSYM_FULL = 3'd4;

   // character slots within one group
   localparam logic [2:0] SLOT_CR   = 3'd4;
   localparam logic [2:0] SLOT_LF   = 3'd5;
   localparam logic [2:0] SLOT_LAST = 3'd3;

   typedef struct packed {
      logic [3:0][5:0] sextets;
      logic [2:0]      nsym;
      logic            brk;
      logic            fin;
   } b64le_cmd_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] v8;
      logic [7:0] c;
      v8 = {2'b00, v};
      if (v < 6'd26) begin
         c = 8'd65 + v8;
      end else if (v < 6'd52) begin
         c = 8'd71 + v8;
      end else if (v < 6'd62) begin
         c = v8 - 8'd4;
      end else if (v == 6'd62) begin
         c = 8'd43;
      end else begin
         c = 8'd47;
      end
      return c;
   endfunction

endpackage

### rtl/b64le_if.sv
`timescale 1ns / 1ps
interface b64le_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;
   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64le_char_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_last;
   modport source (output valid, output out_char, output out_last, input ready);
   modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

interface b64le_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] groups_per_line;
   modport source (output valid, output groups_per_line, input ready);
   modport sink   (input valid, input groups_per_line, output ready);
endinterface

### rtl/base64_line_encoder.sv
`timescale 1ns / 1ps
// base64_line_encoder: streaming base64 encoder with crlf line breaks. bytes
// enter on req one per item, final_byte marking the last byte of a message;
// characters leave on rsp one per item, out_last on the final character. the
// front takes a byte every cycle while its two-entry group queue has room and
// groups complete or padded triples; the back sends one character per cycle
// while rsp is ready and a group is queued, so a triple yields four chars
// (six with crlf); the single character output port sets the throughput.
// groups_per_line (reset 19, zero disables breaks) is to be written on csr
// while the block is idle, which the block does not check; csr is always ready.
module base64_line_encoder (
   input logic          clock,
   input logic          reset,
   b64le_byte_if.sink   req,
   b64le_char_if.source rsp,
   b64le_csr_if.sink    csr
);
   import b64le_pkg::*;

   // group commands between front and back
   b64le_cmd_type push_cmd;
   b64le_cmd_type head_cmd;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;

   // front: holds partial groups, counts groups on the line
   b64le_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .csr    (csr),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (push_cmd)
   );

   b64le_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (head_cmd)
   );

   // back: walks a group character by character into the output register
   b64le_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (head_cmd),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

### rtl/b64le_front.sv
`timescale 1ns / 1ps
module b64le_front (
   input  logic                    clock,
   input  logic                    reset,
   b64le_byte_if.sink              req,
   b64le_csr_if.sink               csr,
   input  logic                    q_full,
   output logic                    q_push,
   output b64le_pkg::b64le_cmd_type q_cmd
);
   import b64le_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic [15:0] held_ff, held_in;
   logic [5:0]  gc_ff, gc_in;
   logic [5:0]  gpl_ff;
   logic [5:0]  gc_inc;
   logic        accept;
   logic [7:0]  b, b0;

   assign req.ready = !q_full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign b         = req.data_byte;
   assign gc_inc    = gc_ff + 6'd1;

   always_comb begin
      q_cmd    = '0;
      q_push   = 1'b0;
      phase_in = phase_ff;
      held_in  = held_ff;
      gc_in    = gc_ff;
      b0       = held_ff[7:0];
      q_cmd.fin = req.final_byte;
      unique case (phase_ff)
         2'd0: begin
            q_cmd.sextets[0] = b[7:2];
            q_cmd.sextets[1] = {b[1:0], 4'b0000};
            q_cmd.nsym       = NSYM_PAD2;
            q_push           = accept && req.final_byte;
            if (accept) begin
               phase_in = 2'd1;
               held_in  = {8'h00, b};
            end
         end
         2'd1: begin
            q_cmd.sextets[0] = b0[7:2];
            q_cmd.sextets[1] = {b0[1:0], b[7:4]};
            q_cmd.sextets[2] = {b[3:0], 2'b00};
            q_cmd.nsym       = NSYM_PAD1;
            q_push           = accept && req.final_byte;
            if (accept) begin
               phase_in = 2'd2;
               held_in  = {b0, b};
            end
         end
         default: begin
            // two bytes held: complete group
            q_cmd.sextets[0] = held_ff[15:10];
            q_cmd.sextets[1] = {held_ff[9:8], held_ff[7:4]};
            q_cmd.sextets[2] = {held_ff[3:0], b[7:6]};
            q_cmd.sextets[3] = b[5:0];
            q_cmd.nsym       = NSYM_FULL;
            q_cmd.brk        = (gpl_ff != 6'd0) && (gc_inc >= gpl_ff);
            q_push           = accept;
            if (accept) begin
               phase_in = 2'd0;
               held_in  = 16'h0000;
               gc_in    = q_cmd.brk ? 6'd0 : gc_inc;
            end
         end
      endcase
      if (accept && req.final_byte) begin
         phase_in = 2'd0;
         held_in  = 16'h0000;
         gc_in    = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         held_ff  <= 16'h0000;
         gc_ff    <= 6'd0;
         gpl_ff   <= GPL_RESET;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         gc_ff    <= gc_in;
         if (csr.valid) begin
            gpl_ff <= csr.groups_per_line;
         end
      end
   end

`ifndef ASSERT_OFF
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3) else $error("phase out of range");
   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.final_byte |=> phase_ff == 2'd0 && gc_ff == 6'd0)
      else $error("state not cleared after final byte");
`endif

endmodule

### rtl/b64le_queue.sv
`timescale 1ns / 1ps
module b64le_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  b64le_pkg::b64le_cmd_type push_cmd,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output b64le_pkg::b64le_cmd_type head
);
   import b64le_pkg::*;

   b64le_cmd_type          mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ff, rd_ff;
   logic [QUEUE_AW:0]      count_ff;

   assign full  = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("queue underflow");
`endif

endmodule

### rtl/b64le_back.sv
`timescale 1ns / 1ps
module b64le_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  b64le_pkg::b64le_cmd_type q_head,
   output logic                     q_pop,
   b64le_char_if.source             rsp
);
   import b64le_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic       end_slot;

   assign rsp.valid    = valid_ff;
   assign rsp.out_char = char_ff;
   assign rsp.out_last = last_ff;

   assign load     = !valid_ff || rsp.ready;
   assign end_slot = q_head.brk ? (idx_ff == SLOT_LF) : (idx_ff == SLOT_LAST);
   assign q_pop    = load && !q_empty && end_slot;

   always_comb begin
      if (idx_ff < q_head.nsym) begin
         char_in = b64_char(q_head.sextets[idx_ff[1:0]]);
      end else if (idx_ff < SLOT_CR) begin
         char_in = CHAR_PAD;
      end else if (idx_ff == SLOT_CR) begin
         char_in = CHAR_CR;
      end else begin
         char_in = CHAR_LF;
      end
      last_in  = q_head.fin && end_slot;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            idx_in = end_slot ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && !q_empty) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

`ifndef ASSERT_OFF
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= SLOT_LF) else $error("character slot out of range");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import b64le_pkg::*;

   localparam int    HALF_PERIOD    = 2;
   localparam int    RESET_CYCLES   = 6;
   localparam int    LATENCY_PAD    = 20;    // quiet cycles after the last expected char
   localparam int    HOLD_CYCLES    = 200;   // long receiver hold-off
   localparam int    WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
   localparam int    ROUND_BYTES    = 12;    // random bytes per idle setting
   localparam int    STALL_BYTES    = 30;    // message that piles up during the hold-off
   localparam string B64_ALPHABET   =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // bytes held by the encoder between groups
   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_ONE  = 2'd1;
   localparam logic [1:0] HELD_TWO  = 2'd2;

   typedef struct {
      logic [7:0] data;
      logic       fin;
   } byte_item_type;

   typedef struct {
      logic [7:0] code;
      logic       last;
   } char_item_type;

   logic clock;
   logic reset;

   b64le_byte_if req_bus ();
   b64le_char_if rsp_bus ();
   b64le_csr_if  csr_bus ();

   base64_line_encoder uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source),
      .csr   (csr_bus.sink)
   );

   // bytes waiting for the driver, chars waiting for the block
   byte_item_type pending_bytes[$];
   char_item_type expected_chars[$];

   // encoder state as predicted
   logic [5:0]  line_groups;
   logic [1:0]  held_count;
   logic [15:0] held_pair;
   logic [5:0]  groups_on_line;

   int  bytes_queued;
   int  bytes_accepted;
   int  chars_checked;
   int  mismatch_count;
   int  message_count;
   int  csr_writes;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  stall_requests;
   int  stall_served;
   int  hold_left;
   int  quiet_cycles;
   bit  byte_taken;

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #(HALF_PERIOD) clock = ~clock;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   function automatic logic [7:0] sextet_code(input logic [5:0] v);
      return B64_ALPHABET[v];
   endfunction

   function automatic void push_char(input logic [7:0] code, input logic last);
      char_item_type c;
      c.code = code;
      c.last = last;
      expected_chars.push_back(c);
   endfunction

   // one byte in, zero to six chars out
   function automatic void encode_byte(input logic [7:0] b, input logic fin);
      logic [7:0] b0;
      logic [7:0] b1;
      logic       brk;
      case (held_count)
         HELD_NONE: begin
            if (!fin) begin
               held_pair  = {8'h00, b};
               held_count = HELD_ONE;
               return;
            end
            // lone byte: two chars then two pads
            push_char(sextet_code(b[7:2]), 1'b0);
            push_char(sextet_code({b[1:0], 4'b0000}), 1'b0);
            push_char(CHAR_PAD, 1'b0);
            push_char(CHAR_PAD, 1'b1);
         end
         HELD_ONE: begin
            b0 = held_pair[7:0];
            if (!fin) begin
               held_pair  = {b0, b};
               held_count = HELD_TWO;
               return;
            end
            // two bytes: three chars then one pad
            push_char(sextet_code(b0[7:2]), 1'b0);
            push_char(sextet_code({b0[1:0], b[7:4]}), 1'b0);
            push_char(sextet_code({b[3:0], 2'b00}), 1'b0);
            push_char(CHAR_PAD, 1'b1);
         end
         default: begin
            // complete triple; the line counter wraps at six bits
            b0 = held_pair[15:8];
            b1 = held_pair[7:0];
            groups_on_line = groups_on_line + 6'd1;
            brk = (line_groups != 6'd0) && (groups_on_line >= line_groups);
            push_char(sextet_code(b0[7:2]), 1'b0);
            push_char(sextet_code({b0[1:0], b1[7:4]}), 1'b0);
            push_char(sextet_code({b1[3:0], b[7:6]}), 1'b0);
            push_char(sextet_code(b[5:0]), fin && !brk);
            if (brk) begin
               push_char(CHAR_CR, 1'b0);
               push_char(CHAR_LF, fin);
               groups_on_line = 6'd0;
            end
            held_count = HELD_NONE;
            held_pair  = 16'h0000;
         end
      endcase
      // end of message clears everything
      if (fin) begin
         held_count     = HELD_NONE;
         held_pair      = 16'h0000;
         groups_on_line = 6'd0;
      end
   endfunction

   // ------------------------------------------------------------------
   // driver: offers pending bytes at the falling edge, idles at random
   // ------------------------------------------------------------------

   always @(negedge clock) begin : byte_driver
      byte_item_type nxt;
      if (!reset) begin
         // slot is free when nothing is offered or the last offer was taken
         if (!req_bus.valid || byte_taken) begin
            byte_taken = 1'b0;
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_bytes.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.data_byte  <= nxt.data;
               req_bus.final_byte <= nxt.fin;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random ready, plus a long hold-off on request
   always @(negedge clock) begin
      if (stall_served != stall_requests) begin
         stall_served = stall_served + 1;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // monitor: predicts on accepted bytes, then checks accepted chars
   // ------------------------------------------------------------------

   always @(posedge clock) begin : char_monitor
      char_item_type want;
      if (!reset) begin
         // byte first, in case a char could leave at the same edge
         if (req_bus.valid && req_bus.ready) begin
            encode_byte(req_bus.data_byte, req_bus.final_byte);
            bytes_accepted = bytes_accepted + 1;
            byte_taken     = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            chars_checked = chars_checked + 1;
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected char: expected none, actual code %0d last %0b",
                        $time, rsp_bus.out_char, rsp_bus.out_last);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_bus.out_char !== want.code || rsp_bus.out_last !== want.last) begin
                  $display("%0t: char mismatch: expected code %0d last %0b, actual code %0d last %0b",
                           $time, want.code, want.last, rsp_bus.out_char, rsp_bus.out_last);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
      end
   end

   // watchdog: a long run of cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d chars still expected",
                  $time, quiet_cycles, expected_chars.size());
         $display("base64_line_encoder: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   task automatic queue_byte(input logic [7:0] data, input logic fin);
      byte_item_type item;
      item.data = data;
      item.fin  = fin;
      pending_bytes.push_back(item);
      bytes_queued = bytes_queued + 1;
   endtask

   // random bytes with the extremes weighted in
   task automatic queue_message(input int len, input bit with_final);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(255));
         endcase
         queue_byte(b, with_final && (i == len - 1));
      end
      if (with_final) message_count = message_count + 1;
   endtask

   // every byte in, every expected char out, then a quiet pause
   task automatic wait_idle();
      while (bytes_accepted != bytes_queued || expected_chars.size() != 0)
         @(posedge clock);
      repeat (LATENCY_PAD) @(posedge clock);
   endtask

   // line length write; only called while the block is idle
   task automatic set_line_length(input logic [5:0] groups);
      @(negedge clock);
      csr_bus.valid           <= 1'b1;
      csr_bus.groups_per_line <= groups;
      do @(posedge clock); while (!csr_bus.ready);
      line_groups = groups;
      csr_writes  = csr_writes + 1;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin : stimulus
      int target;

      // known values on every input from time zero
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.data_byte       = 8'h00;
      req_bus.final_byte      = 1'b0;
      rsp_bus.ready           = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.groups_per_line = 6'd0;
      line_groups             = GPL_RESET;
      held_count              = HELD_NONE;
      held_pair               = 16'h0000;
      groups_on_line          = 6'd0;
      bytes_queued            = 0;
      bytes_accepted          = 0;
      chars_checked           = 0;
      mismatch_count          = 0;
      message_count           = 0;
      csr_writes              = 0;
      stall_requests          = 0;
      stall_served            = 0;
      hold_left               = 0;
      quiet_cycles            = 0;
      byte_taken              = 1'b0;
      send_idle_pct           = 23;
      recv_idle_pct           = 56;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, reset line length
      queue_byte(8'h00, 1'b1);                          // lone byte, low extreme
      queue_byte(8'hFF, 1'b1);                          // lone byte, high extreme
      queue_byte(8'h00, 1'b0); queue_byte(8'hFF, 1'b1); // two bytes, one pad
      queue_byte(8'hFF, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'hFF, 1'b1);
      queue_byte(8'h4D, 1'b0); queue_byte(8'h61, 1'b0); queue_byte(8'h6E, 1'b1);
      // all-zero and all-one groups carried into a padded tail
      queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0);
      queue_byte(8'h12, 1'b0); queue_byte(8'h34, 1'b1);
      message_count = 6;
      wait_idle();

      // one group per line: final group fills the line, last flag on LF
      set_line_length(6'd1);
      queue_byte(8'hFB, 1'b0); queue_byte(8'hEF, 1'b0); queue_byte(8'hBE, 1'b1);
      // break after a full group, padded tail gets no break
      queue_byte(8'h01, 1'b0); queue_byte(8'h02, 1'b0); queue_byte(8'h03, 1'b0);
      queue_byte(8'h04, 1'b1);
      message_count = message_count + 2;
      wait_idle();

      // breaks disabled
      set_line_length(6'd0);
      queue_message(7, 1'b1);
      wait_idle();

      // line length lowered mid-line: three groups, then down to two
      set_line_length(6'd63);
      queue_message(9, 1'b0);
      wait_idle();
      set_line_length(6'd2);
      queue_message(4, 1'b1);
      wait_idle();

      // random part over three idle settings
      for (int round = 0; round < 3; round++) begin
         case (round)
            0: begin send_idle_pct = 23; recv_idle_pct = 56; end
            1: begin send_idle_pct = 56; recv_idle_pct = 23; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         target = bytes_queued + ROUND_BYTES;
         if (round == 2) begin
            // receiver holds off while a long message piles up at the input
            stall_requests = stall_requests + 1;
            queue_message(STALL_BYTES, 1'b1);
         end
         while (bytes_queued < target) begin
            if ($urandom_range(2) == 0) begin
               wait_idle();
               case ($urandom_range(5))
                  0:       set_line_length(6'd0);
                  1:       set_line_length(6'd63);
                  2:       set_line_length(6'd1);
                  3:       set_line_length(6'd2);
                  4:       set_line_length(GPL_RESET);
                  default: set_line_length(6'($urandom_range(63)));
               endcase
            end
            queue_message($urandom_range(1, 12), 1'b1);
         end
      end
      wait_idle();

      $display("covered %0d bytes in %0d messages, %0d chars checked, %0d line length writes",
               bytes_accepted, message_count, chars_checked, csr_writes);
      $display("padding, line breaks from 0 to 63 groups, a lowered line length and a long output stall");
      if (mismatch_count == 0) begin
         $display("base64_line_encoder: match");
      end else begin
         $display("base64_line_encoder: mismatch");
      end
      $finish;
   end

endmodule
